/* hdl/triangle_tangent_frame_assert.svh */
// assertion macros for the file that asserts (the top level)
`ifndef TRIANGLE_TANGENT_FRAME_ASSERT_SVH
`define TRIANGLE_TANGENT_FRAME_ASSERT_SVH

// same-cycle implication, sampled on clk_i and quiet during reset
`define TTF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in triangle tangent frame");

// next-cycle implication
`define TTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in triangle tangent frame");

`endif

/* hdl/ttf_pkg.sv */
`timescale 1ns / 1ps

package ttf_pkg;

  // port widths
  localparam int POS_W = 48;
  localparam int UV_W  = 32;
  localparam int VEC_W = 48;
  localparam int OUT_W = 16;

  localparam int COORD_WIDTH_DEF = 16;

  // fixed-point scaling of the unit vectors
  localparam int OUT_FRAC   = 14;
  localparam int SHRINK_MSB = 14;
  localparam int NORM_MSB   = 29;
  localparam int MAG_W      = 30;
  localparam int SQ_W       = 62;
  localparam int LEN_W      = 31;
  localparam int SQRT_STEPS = 31;
  localparam int Q_W        = 15;
  localparam int NUM_W      = 46;

  typedef enum logic [1:0] {
    CORNER_0 = 2'd0,
    CORNER_1 = 2'd1,
    CORNER_2 = 2'd2
  } corner_e;

  typedef struct packed {
    corner_e corner;
    logic    last;
    logic    degen;
  } meta_t;

  // index of the highest set bit, zero for an empty word
  function automatic logic [5:0] msb_idx(input logic [63:0] w);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

/* hdl/ttf_issue.sv */
`timescale 1ns / 1ps

module ttf_issue #(
  parameter int W = ttf_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ttf_pkg::POS_W-1:0] pos_a_i,
  input  logic [ttf_pkg::POS_W-1:0] pos_b_i,
  input  logic [ttf_pkg::POS_W-1:0] pos_c_i,
  input  logic [ttf_pkg::UV_W-1:0]  uv_a_i,
  input  logic [ttf_pkg::UV_W-1:0]  uv_b_i,
  input  logic [ttf_pkg::UV_W-1:0]  uv_c_i,
  input  logic [ttf_pkg::POS_W-1:0] nrm_a_i,
  input  logic [ttf_pkg::POS_W-1:0] nrm_b_i,
  input  logic [ttf_pkg::POS_W-1:0] nrm_c_i,
  output logic                      valid_o,
  output ttf_pkg::meta_t            meta_o,
  output logic signed [W-1:0]       pa_o [3],
  output logic signed [W-1:0]       pb_o [3],
  output logic signed [W-1:0]       pd_o [3],
  output logic signed [W-1:0]       ua_o [2],
  output logic signed [W-1:0]       ub_o [2],
  output logic signed [W-1:0]       ud_o [2],
  output logic signed [W-1:0]       na_o [3]
);

  function automatic logic signed [W-1:0] fld(input logic [63:0] w, input logic [1:0] k);
    return w[k*W +: W];
  endfunction

  logic [1:0] cnt_q, cnt_d;
  logic       acc;
  logic [ttf_pkg::POS_W-1:0] pos_a_q, pos_b_q, pos_c_q, nrm_a_q, nrm_b_q, nrm_c_q;
  logic [ttf_pkg::UV_W-1:0]  uv_a_q, uv_b_q, uv_c_q;
  ttf_pkg::corner_e corner;
  logic [63:0] pa_w, pb_w, pd_w, ua_w, ub_w, ud_w, na_w;

  logic                valid_q;
  ttf_pkg::meta_t      meta_q;
  logic signed [W-1:0] pa_q [3], pb_q [3], pd_q [3], na_q [3];
  logic signed [W-1:0] ua_q [2], ub_q [2], ud_q [2];

  // triangle transfer and corner counter
  assign busy = (cnt_q > 2'd1);
  assign acc  = start && !busy;

  always_comb begin
    cnt_d = cnt_q;
    if (cnt_q != 2'd0) cnt_d = cnt_q - 2'd1;
    if (acc) cnt_d = 2'd3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pos_a_q <= pos_a_i;
      pos_b_q <= pos_b_i;
      pos_c_q <= pos_c_i;
      uv_a_q  <= uv_a_i;
      uv_b_q  <= uv_b_i;
      uv_c_q  <= uv_c_i;
      nrm_a_q <= nrm_a_i;
      nrm_b_q <= nrm_b_i;
      nrm_c_q <= nrm_c_i;
    end
  end

  // corner decode from the countdown
  always_comb begin
    unique case (cnt_q)
      2'd3:    corner = ttf_pkg::CORNER_0;
      2'd2:    corner = ttf_pkg::CORNER_1;
      default: corner = ttf_pkg::CORNER_2;
    endcase
  end

  // corner triple selection
  always_comb begin
    unique case (corner)
      ttf_pkg::CORNER_1: begin
        pa_w = 64'(pos_b_q); pb_w = 64'(pos_a_q); pd_w = 64'(pos_c_q);
        ua_w = 64'(uv_b_q);  ub_w = 64'(uv_a_q);  ud_w = 64'(uv_c_q);
        na_w = 64'(nrm_b_q);
      end
      ttf_pkg::CORNER_2: begin
        pa_w = 64'(pos_c_q); pb_w = 64'(pos_b_q); pd_w = 64'(pos_a_q);
        ua_w = 64'(uv_c_q);  ub_w = 64'(uv_b_q);  ud_w = 64'(uv_a_q);
        na_w = 64'(nrm_c_q);
      end
      default: begin
        pa_w = 64'(pos_a_q); pb_w = 64'(pos_b_q); pd_w = 64'(pos_c_q);
        ua_w = 64'(uv_a_q);  ub_w = 64'(uv_b_q);  ud_w = 64'(uv_c_q);
        na_w = 64'(nrm_a_q);
      end
    endcase
  end

  // issue register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cnt_q != 2'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    meta_q.corner <= corner;
    meta_q.last   <= (corner == ttf_pkg::CORNER_2);
    meta_q.degen  <= 1'b0;
    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= fld(pa_w, 2'(k));
      pb_q[k] <= fld(pb_w, 2'(k));
      pd_q[k] <= fld(pd_w, 2'(k));
      na_q[k] <= fld(na_w, 2'(k));
    end
    for (int k = 0; k < 2; k++) begin
      ua_q[k] <= fld(ua_w, 2'(k));
      ub_q[k] <= fld(ub_w, 2'(k));
      ud_q[k] <= fld(ud_w, 2'(k));
    end
  end

  assign valid_o = valid_q;
  assign meta_o  = meta_q;
  assign pa_o    = pa_q;
  assign pb_o    = pb_q;
  assign pd_o    = pd_q;
  assign na_o    = na_q;
  assign ua_o    = ua_q;
  assign ub_o    = ub_q;
  assign ud_o    = ud_q;

endmodule

/* hdl/ttf_raw.sv */
`timescale 1ns / 1ps

module ttf_raw #(
  parameter int W = ttf_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  ttf_pkg::meta_t      meta_i,
  input  logic signed [W-1:0] pa_i [3],
  input  logic signed [W-1:0] pb_i [3],
  input  logic signed [W-1:0] pd_i [3],
  input  logic signed [W-1:0] ua_i [2],
  input  logic signed [W-1:0] ub_i [2],
  input  logic signed [W-1:0] ud_i [2],
  input  logic signed [W-1:0] na_i [3],
  output logic                valid_o,
  output ttf_pkg::meta_t      meta_o,
  output logic [2*W+1:0]      tmag_o [3],
  output logic                tsgn_o [3],
  output logic [2*W+1:0]      bmag_o [3],
  output logic                bsgn_o [3],
  output logic signed [W-1:0] nrm_o [3]
);

  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int SW = 2 * W + 3;

  logic           vld_q [3];
  ttf_pkg::meta_t mt_q [3];

  logic signed [DW-1:0] dpb1_q [3], dpc1_q [3];
  logic signed [DW-1:0] tb0_q, tb1_q, tc0_q, tc1_q;
  logic signed [W-1:0]  n1_q [3], n2_q [3], n3_q [3];

  logic signed [PW-1:0] pt1_q [3], pt2_q [3], pb1_q [3], pb2_q [3];
  logic signed [PW-1:0] d1_q, d2_q;

  logic signed [SW-1:0] t_c [3], b_c [3], t_n [3], b_n [3];
  logic signed [SW-1:0] det_c;
  logic [2*W+1:0]       tmag_q [3], bmag_q [3];
  logic                 tsgn_q [3], bsgn_q [3];
  logic                 degen_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      vld_q[1] <= vld_q[0];
      vld_q[2] <= vld_q[1];
    end
  end

  // edge and uv deltas
  always_ff @(posedge clk_i) begin
    mt_q[0] <= meta_i;
    for (int i = 0; i < 3; i++) begin
      dpb1_q[i] <= DW'(pb_i[i]) - DW'(pa_i[i]);
      dpc1_q[i] <= DW'(pd_i[i]) - DW'(pa_i[i]);
      n1_q[i]   <= na_i[i];
    end
    tb0_q <= DW'(ub_i[0]) - DW'(ua_i[0]);
    tb1_q <= DW'(ub_i[1]) - DW'(ua_i[1]);
    tc0_q <= DW'(ud_i[0]) - DW'(ua_i[0]);
    tc1_q <= DW'(ud_i[1]) - DW'(ua_i[1]);
  end

  // products
  always_ff @(posedge clk_i) begin
    mt_q[1] <= mt_q[0];
    for (int i = 0; i < 3; i++) begin
      pt1_q[i] <= dpb1_q[i] * tc1_q;
      pt2_q[i] <= dpc1_q[i] * tb1_q;
      pb1_q[i] <= dpc1_q[i] * tb0_q;
      pb2_q[i] <= dpb1_q[i] * tc0_q;
      n2_q[i]  <= n1_q[i];
    end
    d1_q <= tb0_q * tc1_q;
    d2_q <= tb1_q * tc0_q;
  end

  // raw tangent, bitangent and determinant sign
  always_comb begin
    det_c = SW'(d1_q) - SW'(d2_q);
    for (int i = 0; i < 3; i++) begin
      t_c[i] = SW'(pt1_q[i]) - SW'(pt2_q[i]);
      b_c[i] = SW'(pb1_q[i]) - SW'(pb2_q[i]);
      t_n[i] = -t_c[i];
      b_n[i] = -b_c[i];
    end
  end

  always_ff @(posedge clk_i) begin
    mt_q[2].corner <= mt_q[1].corner;
    mt_q[2].last   <= mt_q[1].last;
    mt_q[2].degen  <= mt_q[1].degen;
    degen_q        <= (det_c == '0);
    for (int i = 0; i < 3; i++) begin
      tsgn_q[i] <= t_c[i][SW-1] ^ det_c[SW-1];
      bsgn_q[i] <= b_c[i][SW-1] ^ det_c[SW-1];
      tmag_q[i] <= t_c[i][SW-1] ? t_n[i][2*W+1:0] : t_c[i][2*W+1:0];
      bmag_q[i] <= b_c[i][SW-1] ? b_n[i][2*W+1:0] : b_c[i][2*W+1:0];
      n3_q[i]   <= n2_q[i];
    end
  end

  always_comb begin
    meta_o       = mt_q[2];
    meta_o.degen = mt_q[2].degen | degen_q;
  end

  assign valid_o = vld_q[2];
  assign tmag_o  = tmag_q;
  assign tsgn_o  = tsgn_q;
  assign bmag_o  = bmag_q;
  assign bsgn_o  = bsgn_q;
  assign nrm_o   = n3_q;

endmodule

/* hdl/ttf_unit.sv */
`timescale 1ns / 1ps

module ttf_unit #(
  parameter int W = ttf_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  ttf_pkg::meta_t            meta_i,
  input  logic [2*W+1:0]            mag_i [3],
  input  logic                      sgn_i [3],
  input  logic signed [W-1:0]       nrm_i [3],
  output logic                      valid_o,
  output ttf_pkg::meta_t            meta_o,
  output logic [ttf_pkg::VEC_W-1:0] vec_o,
  output logic                      zero_o
);

  localparam int MW    = 2 * W + 2;
  localparam int NNW   = 2 * W + 1;
  localparam int NVW   = W + 17;
  localparam int NN_LO = NNW / 2;
  localparam int NN_HI = NNW - NN_LO;
  localparam int NV_LO = NVW / 2;
  localparam int NV_HI = NVW - NV_LO;
  localparam int RW    = 2 * W + 17;
  localparam int RMW   = 2 * W + 16;
  localparam int FRONT = 11;
  localparam int SQS   = ttf_pkg::SQRT_STEPS;
  localparam int QW    = ttf_pkg::Q_W;
  localparam int NMW   = ttf_pkg::NUM_W;
  localparam int MGW   = ttf_pkg::MAG_W;
  localparam int SQW   = ttf_pkg::SQ_W;
  localparam int LW    = ttf_pkg::LEN_W;
  localparam int OW    = ttf_pkg::OUT_W;

  // front control chain
  logic           vf_q [FRONT];
  ttf_pkg::meta_t mf_q [FRONT];

  // shrink
  logic [MW-1:0]       m1_q [3];
  logic                g1_q [3];
  logic signed [W-1:0] n1_q [3], n2_q [3], n3_q [3], n4_q [3];
  logic [5:0]          sh1_c, sh1_q;
  logic [5:0]          p1_c;
  logic signed [15:0]  v2_q [3], v3_q [3], v4_q [3];
  logic [MW-1:0]       vs_c [3];

  // orthogonalisation
  logic signed [2*W-1:0]    nsq3_q [3];
  logic signed [W+15:0]     nvp3_q [3];
  logic signed [NNW-1:0]    nn4_q;
  logic signed [NVW-1:0]    nv4_q;
  logic signed [16+NN_HI-1:0] ah5_q [3];
  logic signed [17+NN_LO-1:0] al5_q [3];
  logic signed [W+NV_HI-1:0]  bh5_q [3];
  logic signed [W+NV_LO:0]    bl5_q [3];
  logic signed [RW-1:0]     a6_q [3], b6_q [3], r7_c [3];
  logic [RMW-1:0]           m7_q [3];
  logic                     g7_q [3];

  // normalise and square
  logic [RMW-1:0] m8_q [3];
  logic           g8_q [3], g9_q [3], g10_q [3], g11_q [3];
  logic [5:0]     p8_q;
  logic           z8_q, z9_q, z10_q, z11_q;
  logic [MGW-1:0] m9_q [3], m10_q [3], m11_q [3], m9_c [3];
  logic [2*MGW-1:0] sq10_q [3];
  logic [SQW-1:0] s11_q;

  // square root chain
  logic           sv_q [SQS];
  ttf_pkg::meta_t smt_q [SQS];
  logic [SQW-1:0] ss_q [SQS], sr_q [SQS], ss_d [SQS], sr_d [SQS];
  logic [MGW-1:0] sm_q [SQS][3];
  logic           sg_q [SQS][3];
  logic           sz_q [SQS];

  // numerator
  logic           nv_q;
  ttf_pkg::meta_t nmt_q;
  logic [NMW-1:0] num_q [3];
  logic [LW-1:0]  nl_q, len_c;
  logic           ng_q [3];
  logic           nz_q;

  // division chain
  logic           dv_q [QW];
  ttf_pkg::meta_t dmt_q [QW];
  logic [NMW-1:0] dr_q [QW][3], dr_d [QW][3];
  logic [QW-1:0]  dq_q [QW][3], dq_d [QW][3];
  logic [LW-1:0]  dl_q [QW];
  logic           dg_q [QW][3];
  logic           dz_q [QW];

  // result
  logic           fv_q;
  ttf_pkg::meta_t fmt_q;
  logic [ttf_pkg::VEC_W-1:0] fvec_q;
  logic           fz_q;

  // front valid and meta
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRONT; k++) vf_q[k] <= 1'b0;
    end else begin
      vf_q[0] <= valid_i;
      for (int k = 1; k < FRONT; k++) vf_q[k] <= vf_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    mf_q[0] <= meta_i;
    for (int k = 1; k < FRONT; k++) mf_q[k] <= mf_q[k-1];
  end

  // shrink amount search
  always_comb begin
    p1_c  = ttf_pkg::msb_idx(64'(mag_i[0] | mag_i[1] | mag_i[2]));
    sh1_c = (p1_c > 6'(ttf_pkg::SHRINK_MSB)) ? (p1_c - 6'(ttf_pkg::SHRINK_MSB)) : 6'd0;
  end

  always_ff @(posedge clk_i) begin
    sh1_q <= sh1_c;
    for (int i = 0; i < 3; i++) begin
      m1_q[i] <= mag_i[i];
      g1_q[i] <= sgn_i[i];
      n1_q[i] <= nrm_i[i];
    end
  end

  // block shift into 16-bit signed
  always_comb begin
    for (int i = 0; i < 3; i++) vs_c[i] = m1_q[i] >> sh1_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      v2_q[i] <= g1_q[i] ? -$signed({1'b0, vs_c[i][14:0]}) : $signed({1'b0, vs_c[i][14:0]});
      n2_q[i] <= n1_q[i];
    end
  end

  // n.n and n.v terms
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      nsq3_q[i] <= n2_q[i] * n2_q[i];
      nvp3_q[i] <= n2_q[i] * v2_q[i];
      v3_q[i]   <= v2_q[i];
      n3_q[i]   <= n2_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    nn4_q <= NNW'(nsq3_q[0]) + NNW'(nsq3_q[1]) + NNW'(nsq3_q[2]);
    nv4_q <= NVW'(nvp3_q[0]) + NVW'(nvp3_q[1]) + NVW'(nvp3_q[2]);
    for (int i = 0; i < 3; i++) begin
      v4_q[i] <= v3_q[i];
      n4_q[i] <= n3_q[i];
    end
  end

  // split partial products of v*nn and n*nv
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ah5_q[i] <= v4_q[i] * $signed(nn4_q[NNW-1:NN_LO]);
      al5_q[i] <= v4_q[i] * $signed({1'b0, nn4_q[NN_LO-1:0]});
      bh5_q[i] <= n4_q[i] * $signed(nv4_q[NVW-1:NV_LO]);
      bl5_q[i] <= n4_q[i] * $signed({1'b0, nv4_q[NV_LO-1:0]});
    end
  end

  // recombine partial products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a6_q[i] <= (RW'(ah5_q[i]) <<< NN_LO) + RW'(al5_q[i]);
      b6_q[i] <= (RW'(bh5_q[i]) <<< NV_LO) + RW'(bl5_q[i]);
    end
  end

  // orthogonal vector as sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) r7_c[i] = a6_q[i] - b6_q[i];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      g7_q[i] <= r7_c[i][RW-1];
      m7_q[i] <= r7_c[i][RW-1] ? RMW'(-r7_c[i]) : RMW'(r7_c[i]);
    end
  end

  // normalising shift search
  always_ff @(posedge clk_i) begin
    p8_q <= ttf_pkg::msb_idx(64'(m7_q[0] | m7_q[1] | m7_q[2]));
    z8_q <= ((m7_q[0] | m7_q[1] | m7_q[2]) == '0);
    for (int i = 0; i < 3; i++) begin
      m8_q[i] <= m7_q[i];
      g8_q[i] <= g7_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p8_q >= 6'(ttf_pkg::NORM_MSB)) begin
        m9_c[i] = MGW'(m8_q[i] >> (p8_q - 6'(ttf_pkg::NORM_MSB)));
      end else begin
        m9_c[i] = MGW'(m8_q[i]) << (6'(ttf_pkg::NORM_MSB) - p8_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    z9_q <= z8_q;
    for (int i = 0; i < 3; i++) begin
      m9_q[i] <= m9_c[i];
      g9_q[i] <= g8_q[i];
    end
  end

  // squared length
  always_ff @(posedge clk_i) begin
    z10_q <= z9_q;
    for (int i = 0; i < 3; i++) begin
      sq10_q[i] <= m9_q[i] * m9_q[i];
      m10_q[i]  <= m9_q[i];
      g10_q[i]  <= g9_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    s11_q <= SQW'(sq10_q[0]) + SQW'(sq10_q[1]) + SQW'(sq10_q[2]);
    z11_q <= z10_q;
    for (int i = 0; i < 3; i++) begin
      m11_q[i] <= m10_q[i];
      g11_q[i] <= g10_q[i];
    end
  end

  // square root, one result bit per stage
  always_comb begin
    logic [SQW-1:0] s_in, r_in, bit_c, t_c;
    for (int k = 0; k < SQS; k++) begin
      s_in  = (k == 0) ? s11_q : ss_q[(k == 0) ? 0 : k-1];
      r_in  = (k == 0) ? '0 : sr_q[(k == 0) ? 0 : k-1];
      bit_c = SQW'(1) << (SQW - 2 - 2 * k);
      t_c   = r_in + bit_c;
      if (s_in >= t_c) begin
        ss_d[k] = s_in - t_c;
        sr_d[k] = (r_in >> 1) + bit_c;
      end else begin
        ss_d[k] = s_in;
        sr_d[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQS; k++) sv_q[k] <= 1'b0;
    end else begin
      sv_q[0] <= vf_q[FRONT-1];
      for (int k = 1; k < SQS; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQS; k++) begin
      ss_q[k] <= ss_d[k];
      sr_q[k] <= sr_d[k];
    end
    smt_q[0] <= mf_q[FRONT-1];
    sz_q[0]  <= z11_q;
    for (int i = 0; i < 3; i++) begin
      sm_q[0][i] <= m11_q[i];
      sg_q[0][i] <= g11_q[i];
    end
    for (int k = 1; k < SQS; k++) begin
      smt_q[k] <= smt_q[k-1];
      sz_q[k]  <= sz_q[k-1];
      for (int i = 0; i < 3; i++) begin
        sm_q[k][i] <= sm_q[k-1][i];
        sg_q[k][i] <= sg_q[k-1][i];
      end
    end
  end

  // rounded numerators
  assign len_c = sr_q[SQS-1][LW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
    end else begin
      nv_q <= sv_q[SQS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    nmt_q <= smt_q[SQS-1];
    nz_q  <= sz_q[SQS-1];
    nl_q  <= len_c;
    for (int i = 0; i < 3; i++) begin
      num_q[i] <= (NMW'(sm_q[SQS-1][i]) << ttf_pkg::OUT_FRAC) + NMW'(len_c >> 1);
      ng_q[i]  <= sg_q[SQS-1][i];
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [NMW-1:0] r_in, d_c;
    logic [QW-1:0]  q_in;
    logic [LW-1:0]  l_in;
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        r_in = (j == 0) ? num_q[i] : dr_q[(j == 0) ? 0 : j-1][i];
        q_in = (j == 0) ? '0 : dq_q[(j == 0) ? 0 : j-1][i];
        l_in = (j == 0) ? nl_q : dl_q[(j == 0) ? 0 : j-1];
        d_c  = NMW'(l_in) << (QW - 1 - j);
        if (r_in >= d_c) begin
          dr_d[j][i] = r_in - d_c;
          dq_d[j][i] = q_in | (QW'(1) << (QW - 1 - j));
        end else begin
          dr_d[j][i] = r_in;
          dq_d[j][i] = q_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < QW; j++) dv_q[j] <= 1'b0;
    end else begin
      dv_q[0] <= nv_q;
      for (int j = 1; j < QW; j++) dv_q[j] <= dv_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[j][i] <= dr_d[j][i];
        dq_q[j][i] <= dq_d[j][i];
      end
    end
    dmt_q[0] <= nmt_q;
    dz_q[0]  <= nz_q;
    dl_q[0]  <= nl_q;
    for (int i = 0; i < 3; i++) dg_q[0][i] <= ng_q[i];
    for (int j = 1; j < QW; j++) begin
      dmt_q[j] <= dmt_q[j-1];
      dz_q[j]  <= dz_q[j-1];
      dl_q[j]  <= dl_q[j-1];
      for (int i = 0; i < 3; i++) dg_q[j][i] <= dg_q[j-1][i];
    end
  end

  // signed components packed x low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    fmt_q <= dmt_q[QW-1];
    fz_q  <= dz_q[QW-1];
    for (int i = 0; i < 3; i++) begin
      if (dz_q[QW-1]) begin
        fvec_q[i*OW +: OW] <= '0;
      end else if (dg_q[QW-1][i]) begin
        fvec_q[i*OW +: OW] <= -OW'(dq_q[QW-1][i]);
      end else begin
        fvec_q[i*OW +: OW] <= OW'(dq_q[QW-1][i]);
      end
    end
  end

  assign valid_o = fv_q;
  assign meta_o  = fmt_q;
  assign vec_o   = fvec_q;
  assign zero_o  = fz_q;

endmodule

/* hdl/triangle_tangent_frame.sv */
// triangle tangent frame: three corner frames per triangle
// the corner results of a triangle leave in order, corner 0 first, the others follow
// busy holds off start while the single corner issue slot has more than its last corner to issue
// the result strobe cannot be held off, the pipeline never stalls
// reset clears the corner counter and all valid bits, payload is not reset
`timescale 1ns / 1ps

`include "triangle_tangent_frame_assert.svh"

module triangle_tangent_frame #(
  parameter int COORD_WIDTH = ttf_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [ttf_pkg::POS_W-1:0] pos_a_i,
  input  logic [ttf_pkg::POS_W-1:0] pos_b_i,
  input  logic [ttf_pkg::POS_W-1:0] pos_c_i,
  input  logic [ttf_pkg::UV_W-1:0]  uv_a_i,
  input  logic [ttf_pkg::UV_W-1:0]  uv_b_i,
  input  logic [ttf_pkg::UV_W-1:0]  uv_c_i,
  input  logic [ttf_pkg::POS_W-1:0] nrm_a_i,
  input  logic [ttf_pkg::POS_W-1:0] nrm_b_i,
  input  logic [ttf_pkg::POS_W-1:0] nrm_c_i,
  output logic                      result_valid_o,
  output logic [1:0]                corner_o,
  output logic [ttf_pkg::VEC_W-1:0] tangent_vec_o,
  output logic [ttf_pkg::VEC_W-1:0] bitangent_vec_o,
  output logic                      degenerate_o,
  output logic                      last_o
);

  localparam int W = COORD_WIDTH;

  logic                sel_valid;
  ttf_pkg::meta_t      sel_meta;
  logic signed [W-1:0] pa [3], pb [3], pd [3], na [3];
  logic signed [W-1:0] ua [2], ub [2], ud [2];

  logic                raw_valid;
  ttf_pkg::meta_t      raw_meta;
  logic [2*W+1:0]      tmag [3], bmag [3];
  logic                tsgn [3], bsgn [3];
  logic signed [W-1:0] nrm [3];

  logic                      t_valid, b_valid, t_zero, b_zero, degen;
  ttf_pkg::meta_t            t_meta, b_meta;
  logic [ttf_pkg::VEC_W-1:0] t_vec, b_vec;

  logic                      res_valid_q;
  ttf_pkg::corner_e          corner_q;
  logic [ttf_pkg::VEC_W-1:0] tan_q, bit_q;
  logic                      degen_q, last_q;

  // triangle transfer and corner issue
  ttf_issue #(.W(W)) u_issue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pos_a_i (pos_a_i),
    .pos_b_i (pos_b_i),
    .pos_c_i (pos_c_i),
    .uv_a_i  (uv_a_i),
    .uv_b_i  (uv_b_i),
    .uv_c_i  (uv_c_i),
    .nrm_a_i (nrm_a_i),
    .nrm_b_i (nrm_b_i),
    .nrm_c_i (nrm_c_i),
    .valid_o (sel_valid),
    .meta_o  (sel_meta),
    .pa_o    (pa),
    .pb_o    (pb),
    .pd_o    (pd),
    .ua_o    (ua),
    .ub_o    (ub),
    .ud_o    (ud),
    .na_o    (na)
  );

  // raw tangent and bitangent
  ttf_raw #(.W(W)) u_raw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .meta_i  (sel_meta),
    .pa_i    (pa),
    .pb_i    (pb),
    .pd_i    (pd),
    .ua_i    (ua),
    .ub_i    (ub),
    .ud_i    (ud),
    .na_i    (na),
    .valid_o (raw_valid),
    .meta_o  (raw_meta),
    .tmag_o  (tmag),
    .tsgn_o  (tsgn),
    .bmag_o  (bmag),
    .bsgn_o  (bsgn),
    .nrm_o   (nrm)
  );

  // orthogonalise and normalise both vectors
  ttf_unit #(.W(W)) u_unit_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (raw_valid),
    .meta_i  (raw_meta),
    .mag_i   (tmag),
    .sgn_i   (tsgn),
    .nrm_i   (nrm),
    .valid_o (t_valid),
    .meta_o  (t_meta),
    .vec_o   (t_vec),
    .zero_o  (t_zero)
  );

  ttf_unit #(.W(W)) u_unit_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (raw_valid),
    .meta_i  (raw_meta),
    .mag_i   (bmag),
    .sgn_i   (bsgn),
    .nrm_i   (nrm),
    .valid_o (b_valid),
    .meta_o  (b_meta),
    .vec_o   (b_vec),
    .zero_o  (b_zero)
  );

  // result register
  assign degen = t_meta.degen | t_zero | b_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= t_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    corner_q <= t_meta.corner;
    last_q   <= t_meta.last;
    degen_q  <= degen;
    tan_q    <= degen ? '0 : t_vec;
    bit_q    <= degen ? '0 : b_vec;
  end

  assign result_valid_o  = res_valid_q;
  assign corner_o        = corner_q;
  assign tangent_vec_o   = tan_q;
  assign bitangent_vec_o = bit_q;
  assign degenerate_o    = degen_q;
  assign last_o          = last_q;

  // checks
  `TTF_ASSERT_NOW(a_lanes_aligned, t_valid || b_valid, t_valid && b_valid && (t_meta == b_meta))
  `TTF_ASSERT_NOW(a_degen_zero, result_valid_o && degenerate_o, (tangent_vec_o == '0) && (bitangent_vec_o == '0))
  `TTF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `TTF_ASSERT_NEXT(a_corner_order, result_valid_o && (corner_o == ttf_pkg::CORNER_0), result_valid_o && (corner_o == ttf_pkg::CORNER_1))

endmodule
